FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the Q-learning engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define TQL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TQL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TQL_ASSERT(lbl, prop, msg)
`define TQL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hdl/tql_pkg.sv
// Shared types, constants and a helper function of the Q-learning engine.
package tql_pkg;

	localparam int STATE_COUNT  = 256;
	localparam int ACTION_LIMIT = 4;
	localparam int STATE_W      = 8;
	localparam int ACTION_W     = 2;
	localparam int ADDR_W       = STATE_W + ACTION_W;
	localparam int DEPTH        = STATE_COUNT * ACTION_LIMIT;
	localparam int VALUE_W      = 32;
	localparam int FRAC_ONE     = 65536;

	typedef enum logic [1:0] {
		REG_LEARN_RATE,
		REG_DISCOUNT,
		REG_EXPLORE_PERCENT,
		REG_ACTION_COUNT
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LAST,
		ST_MAX,
		ST_MULG,
		ST_DIFF,
		ST_MULA,
		ST_UPD,
		ST_BEST,
		ST_TIES,
		ST_PICK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              load;
		logic              clear;
		logic              read;
		logic              max;
		logic              mulg;
		logic              diff;
		logic              mula;
		logic              upd;
		logic              best;
		logic              ties;
		logic              pick;
		logic              done;
		logic [ADDR_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic learn;
	} status_t;

	// Remainder of a 16-bit word by a modulus of 1 to 4; division by three
	// uses an exact reciprocal for all 16-bit values.
	function automatic logic [1:0] mod_small(input logic [15:0] v, input logic [2:0] m);
		logic [32:0] p;
		logic [15:0] quo;
		logic [17:0] r;
		p   = {17'd0, v} * 33'd43691;
		quo = p[32:17];
		r   = {2'd0, v} - {2'd0, quo} * 18'd3;
		case (m)
			3'd1:    mod_small = 2'd0;
			3'd2:    mod_small = {1'b0, v[0]};
			3'd3:    mod_small = r[1:0];
			default: mod_small = v[1:0];
		endcase
	endfunction

endpackage

FILE: hdl/tql_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tql_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/tql_ctrl.sv
// Controller state machine that sequences clearing, reads, update and choice.
module tql_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tql_pkg::status_t  status,
	output tql_pkg::cmd_t     cmd,
	output logic              busy
);

	tql_pkg::state_t state_q, state_d;
	logic [tql_pkg::ADDR_W-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tql_pkg::ST_CLEAR: begin
				if (cnt_q == tql_pkg::ADDR_W'(tql_pkg::DEPTH - 1)) state_d = tql_pkg::ST_IDLE;
			end
			tql_pkg::ST_IDLE: begin
				if (start) state_d = tql_pkg::ST_READ;
			end
			tql_pkg::ST_READ: begin
				if (cnt_q == tql_pkg::ADDR_W'(tql_pkg::ACTION_LIMIT)) state_d = tql_pkg::ST_LAST;
			end
			tql_pkg::ST_LAST: state_d = status.learn ? tql_pkg::ST_MAX : tql_pkg::ST_BEST;
			tql_pkg::ST_MAX:  state_d = tql_pkg::ST_MULG;
			tql_pkg::ST_MULG: state_d = tql_pkg::ST_DIFF;
			tql_pkg::ST_DIFF: state_d = tql_pkg::ST_MULA;
			tql_pkg::ST_MULA: state_d = tql_pkg::ST_UPD;
			tql_pkg::ST_UPD:  state_d = tql_pkg::ST_BEST;
			tql_pkg::ST_BEST: state_d = tql_pkg::ST_TIES;
			tql_pkg::ST_TIES: state_d = tql_pkg::ST_PICK;
			tql_pkg::ST_PICK: state_d = tql_pkg::ST_DONE;
			tql_pkg::ST_DONE: state_d = tql_pkg::ST_IDLE;
			default:          state_d = tql_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cnt_d = '0;
		if ((state_q == tql_pkg::ST_CLEAR || state_q == tql_pkg::ST_READ) && state_d == state_q) begin
			cnt_d = cnt_q + 1'b1;
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.cnt = cnt_q;
		unique case (state_q)
			tql_pkg::ST_CLEAR: cmd.clear = 1'b1;
			tql_pkg::ST_IDLE:  cmd.load  = start;
			tql_pkg::ST_READ:  cmd.read  = 1'b1;
			tql_pkg::ST_LAST:  cmd.read  = 1'b0;
			tql_pkg::ST_MAX:   cmd.max   = 1'b1;
			tql_pkg::ST_MULG:  cmd.mulg  = 1'b1;
			tql_pkg::ST_DIFF:  cmd.diff  = 1'b1;
			tql_pkg::ST_MULA:  cmd.mula  = 1'b1;
			tql_pkg::ST_UPD:   cmd.upd   = 1'b1;
			tql_pkg::ST_BEST:  cmd.best  = 1'b1;
			tql_pkg::ST_TIES:  cmd.ties  = 1'b1;
			tql_pkg::ST_PICK:  cmd.pick  = 1'b1;
			tql_pkg::ST_DONE:  cmd.done  = 1'b1;
			default:           cmd.load  = 1'b0;
		endcase
	end

	assign busy = (state_q != tql_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tql_pkg::ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

FILE: hdl/tql_dpath.sv
// Datapath: configuration registers, Q table, update arithmetic and action choice.
module tql_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tql_pkg::cmd_t                 cmd,
	output tql_pkg::status_t              status,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [16:0]                   cfg_data,
	input  logic                          learn,
	input  logic [tql_pkg::STATE_W-1:0]   prev_state,
	input  logic [tql_pkg::ACTION_W-1:0]  prev_action,
	input  logic signed [31:0]            reward,
	input  logic [tql_pkg::STATE_W-1:0]   next_state,
	input  logic [6:0]                    explore_draw,
	input  logic [15:0]                   random_action_draw,
	input  logic [15:0]                   tie_draw,
	output logic                          done,
	output logic [1:0]                    chosen_action,
	output logic                          explored,
	output logic signed [31:0]            updated_value,
	output logic signed [31:0]            best_value
);

	localparam int AL = tql_pkg::ACTION_LIMIT;

	logic [16:0] learn_rate_q, discount_q;
	logic [6:0]  explore_percent_q;
	logic [2:0]  action_count_q;

	logic                         learn_q;
	logic [tql_pkg::STATE_W-1:0]  ps_q, ns_q;
	logic [tql_pkg::ACTION_W-1:0] pa_q;
	logic signed [31:0]           reward_q;
	logic [6:0]                   ed_q;
	logic [15:0]                  rd_q, td_q;

	logic                         ram_we, ram_re;
	logic [tql_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
	logic [31:0]                  ram_wdata, ram_rdata;

	logic                         rd_vld_s1;
	logic [2:0]                   rd_idx_s1;

	logic signed [31:0]           row_q [AL];
	logic signed [31:0]           q_q, m_q, best_q, upd_q, row_max;
	logic signed [49:0]           prod_g_q;
	logic signed [35:0]           diff_q;
	logic signed [53:0]           prod_a_q;
	logic signed [38:0]           nq;
	logic signed [31:0]           nq_sat;
	logic [16:0]                  alpha_sat, gamma_sat;
	logic [2:0]                   n_act, tie_cnt;
	logic [AL-1:0]                eq_q;
	logic [1:0]                   k_q, ex_act_q, pick_act, chosen_q;
	logic                         explore, explored_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q      <= 17'd32768;
			discount_q        <= 17'd58982;
			explore_percent_q <= 7'd10;
			action_count_q    <= 3'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tql_pkg::REG_LEARN_RATE:      learn_rate_q      <= cfg_data;
				tql_pkg::REG_DISCOUNT:        discount_q        <= cfg_data;
				tql_pkg::REG_EXPLORE_PERCENT: explore_percent_q <= cfg_data[6:0];
				tql_pkg::REG_ACTION_COUNT:    action_count_q    <= cfg_data[2:0];
				default:                      action_count_q    <= action_count_q;
			endcase
		end
	end

	always_comb begin
		if (action_count_q == 3'd0) n_act = 3'd1;
		else if (action_count_q > 3'(AL)) n_act = 3'(AL);
		else n_act = action_count_q;
	end

	assign alpha_sat = (learn_rate_q > 17'(tql_pkg::FRAC_ONE)) ? 17'(tql_pkg::FRAC_ONE) : learn_rate_q;
	assign gamma_sat = (discount_q > 17'(tql_pkg::FRAC_ONE)) ? 17'(tql_pkg::FRAC_ONE) : discount_q;
	assign explore   = (ed_q < explore_percent_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_q <= 1'b0;
		end else if (cmd.load) begin
			learn_q <= learn;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ps_q     <= prev_state;
			pa_q     <= prev_action;
			reward_q <= reward;
			ns_q     <= next_state;
			ed_q     <= explore_draw;
			rd_q     <= random_action_draw;
			td_q     <= tie_draw;
		end
	end

	assign status.learn = learn_q;

	// Reads run over the row of next_state, then the entry to be updated.
	assign ram_re    = cmd.read;
	assign ram_raddr = cmd.cnt[2] ? {ps_q, pa_q} : {ns_q, cmd.cnt[1:0]};
	assign ram_we    = cmd.clear | cmd.upd;
	assign ram_waddr = cmd.clear ? cmd.cnt : {ps_q, pa_q};
	assign ram_wdata = cmd.clear ? 32'd0 : nq_sat;

	tql_ram #(
		.WIDTH(tql_pkg::VALUE_W),
		.DEPTH(tql_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_vld_s1 <= cmd.read;
			rd_idx_s1 <= cmd.cnt[2:0];
		end
	end

	always_comb begin
		row_max = row_q[0];
		for (int i = 1; i < AL; i++) begin
			if (3'(i) < n_act && row_q[i] > row_max) row_max = row_q[i];
		end
	end

	assign nq = 39'(q_q) + 39'(prod_a_q >>> 16);

	always_comb begin
		if (nq > 39'sd2147483647) nq_sat = 32'sh7fffffff;
		else if (nq < -39'sd2147483648) nq_sat = 32'sh80000000;
		else nq_sat = nq[31:0];
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_idx_s1[2]) q_q <= ram_rdata;
			else row_q[rd_idx_s1[1:0]] <= ram_rdata;
		end
		// Keep the row copy current when the update lands in the same state.
		if (cmd.upd && ps_q == ns_q) row_q[pa_q] <= nq_sat;
		if (cmd.max) m_q <= row_max;
		if (cmd.mulg) prod_g_q <= $signed({1'b0, gamma_sat}) * m_q;
		if (cmd.diff) diff_q <= 36'(reward_q) + 36'(prod_g_q >>> 16) - 36'(q_q);
		if (cmd.mula) prod_a_q <= $signed({1'b0, alpha_sat}) * diff_q;
		if (cmd.load) upd_q <= '0;
		else if (cmd.upd) upd_q <= nq_sat;
		if (cmd.best) best_q <= row_max;
		if (cmd.ties) begin
			for (int i = 0; i < AL; i++) begin
				eq_q[i] <= (3'(i) < n_act) && (row_q[i] == best_q);
			end
		end
		if (cmd.pick) begin
			k_q      <= tql_pkg::mod_small(td_q, tie_cnt);
			ex_act_q <= tql_pkg::mod_small(rd_q, n_act);
		end
		if (cmd.done) begin
			chosen_q   <= explore ? ex_act_q : pick_act;
			explored_q <= explore;
		end
	end

	always_comb begin
		tie_cnt = '0;
		for (int i = 0; i < AL; i++) begin
			tie_cnt = tie_cnt + {2'd0, eq_q[i]};
		end
	end

	// The k-th tied action in ascending order.
	always_comb begin
		logic [2:0] seen;
		logic       found;
		seen     = '0;
		found    = 1'b0;
		pick_act = '0;
		for (int i = 0; i < AL; i++) begin
			if (eq_q[i] && !found) begin
				if (seen == {1'b0, k_q}) begin
					pick_act = 2'(i);
					found    = 1'b1;
				end else begin
					seen = seen + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.done;
		end
	end

	assign done          = done_q;
	assign chosen_action = chosen_q;
	assign explored      = explored_q;
	assign updated_value = upd_q;
	assign best_value    = best_q;

endmodule

FILE: hdl/tabular_q_learning_engine.sv
// Tabular Q-learning engine: top level joining controller and datapath.
//
// Usage: drive the transition fields and the random draws and pulse start
// while busy is low; the request is taken at that clock edge. One result
// comes back with done high for exactly one cycle, carrying chosen_action,
// explored, updated_value and best_value. The receiver cannot stall it.
// With learn set, the update is computed between the table reads and the
// choice, else it is skipped; the next request may be taken in the done cycle.
// The sequence is set by the single read port of the Q table (five reads per
// request) and the two multiplies of the update done one after the other.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant for idle periods only.
// After reset all 1024 entries of the Q table are cleared, one entry a cycle;
// busy stays high meanwhile and no request is taken, but configuration
// writes are. Configuration registers return to their defaults at reset.
`include "assert_macros.svh"
module tabular_q_learning_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [16:0]                   cfg_data,
	input  logic                          learn,
	input  logic [tql_pkg::STATE_W-1:0]   prev_state,
	input  logic [tql_pkg::ACTION_W-1:0]  prev_action,
	input  logic signed [31:0]            reward,
	input  logic [tql_pkg::STATE_W-1:0]   next_state,
	input  logic [6:0]                    explore_draw,
	input  logic [15:0]                   random_action_draw,
	input  logic [15:0]                   tie_draw,
	output logic [1:0]                    chosen_action,
	output logic                          explored,
	output logic signed [31:0]            updated_value,
	output logic signed [31:0]            best_value
);

	tql_pkg::cmd_t    cmd;
	tql_pkg::status_t status;

	tql_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	tql_dpath u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.learn              (learn),
		.prev_state         (prev_state),
		.prev_action        (prev_action),
		.reward             (reward),
		.next_state         (next_state),
		.explore_draw       (explore_draw),
		.random_action_draw (random_action_draw),
		.tie_draw           (tie_draw),
		.done               (done),
		.chosen_action      (chosen_action),
		.explored           (explored),
		.updated_value      (updated_value),
		.best_value         (best_value)
	);

	`TQL_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
	`TQL_ASSERT(a_done_single, done |=> !done, "done held longer than one cycle")
	`TQL_ASSERT_ALWAYS(a_done_idle, done |-> !busy, "result shown while still busy")

endmodule

FILE: tb/tabular_q_learning_engine_checker.sv
// Checker for the Q-learning engine: predicts each result and compares it with the block.
module tabular_q_learning_engine_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               done,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	input  logic               learn,
	input  logic [7:0]         prev_state,
	input  logic [1:0]         prev_action,
	input  logic signed [31:0] reward,
	input  logic [7:0]         next_state,
	input  logic [6:0]         explore_draw,
	input  logic [15:0]        random_action_draw,
	input  logic [15:0]        tie_draw,
	input  logic [1:0]         chosen_action,
	input  logic               explored,
	input  logic signed [31:0] updated_value,
	input  logic signed [31:0] best_value,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		logic [1:0]         action;
		logic               expl;
		logic signed [31:0] updated;
		logic signed [31:0] best;
	} choice_t;

	logic signed [31:0] q_mirror [tql_pkg::DEPTH];
	logic [16:0]        alpha_reg, gamma_reg;
	logic [6:0]         explore_reg;
	logic [2:0]         count_reg;
	choice_t            expected_choices [$];

	assign pending = expected_choices.size();

	function automatic int actions_used();
		int n;
		n = int'(count_reg);
		if (n == 0) n = 1;
		if (n > tql_pkg::ACTION_LIMIT) n = tql_pkg::ACTION_LIMIT;
		return n;
	endfunction

	function automatic logic signed [31:0] row_best(int base, int n);
		logic signed [31:0] m;
		m = q_mirror[base];
		for (int i = 1; i < n; i++)
			if (q_mirror[base + i] > m) m = q_mirror[base + i];
		return m;
	endfunction

	// Applies one request to the mirrored table and returns the expected choice.
	function automatic choice_t predict_choice();
		choice_t c;
		int n, nbase, idx, ties, pick, seen;
		longint m, q, tgt, nq, a, g;
		n = actions_used();
		nbase = next_state * tql_pkg::ACTION_LIMIT;
		c.expl = 1'b0;
		c.updated = '0;
		c.action = '0;
		if (learn) begin
			a = (alpha_reg > tql_pkg::FRAC_ONE) ? tql_pkg::FRAC_ONE : alpha_reg;
			g = (gamma_reg > tql_pkg::FRAC_ONE) ? tql_pkg::FRAC_ONE : gamma_reg;
			idx = prev_state * tql_pkg::ACTION_LIMIT + prev_action;
			m = row_best(nbase, n);
			q = q_mirror[idx];
			tgt = longint'(reward) + ((g * m) >>> 16);
			nq = q + ((a * (tgt - q)) >>> 16);
			if (nq > 64'sd2147483647) nq = 64'sd2147483647;
			if (nq < -64'sd2147483648) nq = -64'sd2147483648;
			c.updated = nq[31:0];
			q_mirror[idx] = nq[31:0];
		end
		c.best = row_best(nbase, n);
		if (explore_draw < explore_reg) begin
			c.action = 2'(random_action_draw % n);
			c.expl = 1'b1;
		end else begin
			ties = 0;
			seen = 0;
			for (int i = 0; i < n; i++)
				if (q_mirror[nbase + i] == c.best) ties++;
			pick = tie_draw % ties;
			for (int i = 0; i < n; i++) begin
				if (q_mirror[nbase + i] == c.best) begin
					if (seen == pick) begin
						c.action = 2'(i);
						break;
					end
					seen++;
				end
			end
		end
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tql_pkg::DEPTH; i++) q_mirror[i] = '0;
			alpha_reg   = 17'd32768;
			gamma_reg   = 17'd58982;
			explore_reg = 7'd10;
			count_reg   = 3'd2;
			errors      = 0;
			expected_choices.delete();
		end else begin
			if (done) begin
				if (expected_choices.size() == 0) begin
					$display("%0t: result with no request outstanding", $time);
					errors++;
				end else begin
					choice_t e;
					e = expected_choices.pop_front();
					if (chosen_action !== e.action) begin
						$display("%0t: chosen_action expected %0d actual %0d",
							$time, e.action, chosen_action);
						errors++;
					end
					if (explored !== e.expl) begin
						$display("%0t: explored expected %0d actual %0d",
							$time, e.expl, explored);
						errors++;
					end
					if (updated_value !== e.updated) begin
						$display("%0t: updated_value expected %0d actual %0d",
							$time, e.updated, updated_value);
						errors++;
					end
					if (best_value !== e.best) begin
						$display("%0t: best_value expected %0d actual %0d",
							$time, e.best, best_value);
						errors++;
					end
				end
			end
			if (start && !busy) expected_choices.push_back(predict_choice());
			if (cfg_we) begin
				case (tql_pkg::reg_index_t'(cfg_index))
					tql_pkg::REG_LEARN_RATE:      alpha_reg   = cfg_data;
					tql_pkg::REG_DISCOUNT:        gamma_reg   = cfg_data;
					tql_pkg::REG_EXPLORE_PERCENT: explore_reg = cfg_data[6:0];
					tql_pkg::REG_ACTION_COUNT:    count_reg   = cfg_data[2:0];
				endcase
			end
		end
	end

endmodule

FILE: tb/tabular_q_learning_engine_tb.sv
// Testbench top for the Q-learning engine: clock, reset, requests and verdict.
module tabular_q_learning_engine_tb;

	logic               clk, arst_n, start, busy, done;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [16:0]        cfg_data;
	logic               learn;
	logic [7:0]         prev_state, next_state;
	logic [1:0]         prev_action;
	logic signed [31:0] reward;
	logic [6:0]         explore_draw;
	logic [15:0]        random_action_draw, tie_draw;
	logic [1:0]         chosen_action;
	logic               explored;
	logic signed [31:0] updated_value, best_value;
	int                 errors, pending;

	tabular_q_learning_engine u_top (.*);
	tabular_q_learning_engine_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic write_reg(input tql_pkg::reg_index_t idx, input logic [16:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Waits for every result, then lets the block settle before new settings.
	task automatic set_config(input logic [16:0] a, input logic [16:0] g,
			input logic [6:0] e, input logic [2:0] n);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		write_reg(tql_pkg::REG_LEARN_RATE, a);
		write_reg(tql_pkg::REG_DISCOUNT, g);
		write_reg(tql_pkg::REG_EXPLORE_PERCENT, e);
		write_reg(tql_pkg::REG_ACTION_COUNT, n);
	endtask

	task automatic send_request(input logic l, input logic [7:0] ps, input logic [1:0] pa,
			input logic [31:0] r, input logic [7:0] ns, input logic [6:0] ed,
			input logic [15:0] rd, input logic [15:0] td, input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		learn = l;
		prev_state = ps;
		prev_action = pa;
		reward = r;
		next_state = ns;
		explore_draw = ed;
		random_action_draw = rd;
		tie_draw = td;
		start = 1'b1;
		while (busy) @(negedge clk);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic random_request(input int idle_pct);
		logic [7:0]  ps, ns;
		logic [31:0] r;
		// Mostly a few states so values build up and ties break apart.
		ps = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
		ns = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
		case ($urandom_range(3))
			0:       r = $urandom;
			1:       r = ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
			default: r = 32'($signed($urandom_range(0, 2 << 16))) - (1 << 16);
		endcase
		send_request($urandom_range(4) != 0, ps, 2'($urandom), r, ns,
			7'($urandom), 16'($urandom), 16'($urandom), idle_pct);
	endtask

	initial begin
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		learn = 1'b0;
		prev_state = '0;
		prev_action = '0;
		reward = '0;
		next_state = '0;
		explore_draw = '0;
		random_action_draw = '0;
		tie_draw = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Defaults: all-zero rows give full ties, exploration at the edge of the percent.
		send_request(0, 0, 0, 0, 8'd5, 7'd10, 16'hffff, 16'hffff, 0);
		send_request(0, 0, 0, 0, 8'd5, 7'd9, 16'hffff, 16'd3, 0);
		send_request(1, 8'd5, 2'd1, 32'h00010000, 8'd5, 7'd99, 0, 0, 0);
		send_request(1, 8'd255, 2'd3, 32'h80000000, 8'd255, 7'd127, 0, 0, 0);

		// Full rate and discount: a self loop with the largest reward saturates high.
		set_config(17'd65536, 17'd65536, 7'd0, 3'd4);
		repeat (3) send_request(1, 8'd7, 2'd2, 32'h7fffffff, 8'd7, 0, 0, 16'hffff, 0);
		repeat (3) send_request(1, 8'd9, 2'd0, 32'h80000000, 8'd9, 0, 0, 16'd1, 0);
		send_request(1, 8'd3, 2'd3, 32'hffff0000, 8'd7, 7'd100, 16'd5, 16'd2, 0);

		// Rate and discount past one, action count zero, every draw but 127 explores.
		set_config(17'h1ffff, 17'h1ffff, 7'h7f, 3'd0);
		send_request(1, 8'd1, 2'd3, 32'h00012345, 8'd1, 7'd126, 16'hffff, 0, 0);
		send_request(1, 8'd2, 2'd2, 32'hfffe0000, 8'd1, 7'h7f, 16'h1234, 0, 0);

		// Zero rate and discount, action count past the limit, exploration off.
		set_config(17'd0, 17'd0, 7'd0, 3'd7);
		send_request(1, 8'd7, 2'd1, 32'h7fffffff, 8'd7, 7'd0, 0, 16'd7, 0);
		send_request(0, 0, 0, 0, 8'd7, 7'h7f, 0, 16'hffff, 0);

		// Three actions, previous action beyond them, an odd number of ties.
		set_config(17'd40000, 17'd30000, 7'd50, 3'd3);
		send_request(1, 8'd4, 2'd3, 32'h00030000, 8'd6, 7'd49, 16'hfffe, 16'hfffe, 0);
		send_request(0, 0, 0, 0, 8'd6, 7'd50, 16'd0, 16'hfffd, 0);
		send_request(1, 8'd6, 2'd0, 32'h00008000, 8'd4, 7'd70, 16'd1, 16'd2, 0);

		set_config(17'd32768, 17'd58982, 7'd10, 3'd2);
		repeat (420) random_request(26);
		set_config(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
			7'($urandom_range(0, 40)), 3'd4);
		repeat (420) random_request(45);
		set_config(17'($urandom), 17'($urandom), 7'($urandom), 3'($urandom_range(1, 3)));
		repeat (420) random_request(0);
		start = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
